// ===== src/coolant_pid_fan_pump_controller_macros.svh =====
// ----------------------------------------------------------------------------
// Coolant controller assertion macros
// Shared property wrappers for the coolant fan/pump controller checks.
// ----------------------------------------------------------------------------
`ifndef COOLANT_PID_FAN_PUMP_CONTROLLER_MACROS_SVH
`define COOLANT_PID_FAN_PUMP_CONTROLLER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define CPFP_ASSERT_NOW(label, clk, rst_n, cond, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
    else $error("cpfp check failed");

// Next-cycle implication, disabled while reset is asserted
`define CPFP_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
    else $error("cpfp check failed");

`endif

// ===== src/cpfp_pkg.sv =====
// ----------------------------------------------------------------------------
// Coolant controller package
// Codes, band limits and the structs passed between the pipeline stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cpfp_pkg;

  // Fan and pump level codes
  localparam logic [2:0] LVL_OFF  = 3'd0;
  localparam logic [2:0] LVL_LOW  = 3'd1;
  localparam logic [2:0] LVL_AVG  = 3'd2;
  localparam logic [2:0] LVL_HIGH = 3'd3;
  localparam logic [2:0] LVL_MAX  = 3'd4;

  // Status codes
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_SENSOR   = 2'd1;
  localparam logic [1:0] STATUS_OVERHEAT = 2'd2;

  // Sample classes decided in the first stage
  localparam logic [1:0] KIND_FAULT = 2'd0;
  localparam logic [1:0] KIND_HOT   = 2'd1;
  localparam logic [1:0] KIND_COLD  = 2'd2;
  localparam logic [1:0] KIND_RUN   = 2'd3;

  // Configuration register indexes
  localparam logic [2:0] REG_SETPOINT   = 3'd0;
  localparam logic [2:0] REG_GAIN_P     = 3'd1;
  localparam logic [2:0] REG_GAIN_I     = 3'd2;
  localparam logic [2:0] REG_GAIN_D     = 3'd3;
  localparam logic [2:0] REG_HIGH_LIMIT = 3'd4;
  localparam logic [2:0] REG_LOW_MARGIN = 3'd5;
  localparam logic [2:0] REG_SENSOR_ERR = 3'd6;

  // PID band edges (inclusive upper bounds)
  localparam logic signed [15:0] BAND_MAX  = -16'sd50;
  localparam logic signed [15:0] BAND_HIGH = -16'sd40;
  localparam logic signed [15:0] BAND_AVG  = -16'sd30;
  localparam logic signed [15:0] BAND_LOW  = -16'sd20;
  localparam logic signed [15:0] BAND_MIN  = -16'sd10;

  // First-stage word: classification and PID terms
  typedef struct packed {
    logic [1:0]  kind;
    logic        rep_v;
    logic        rep_o;
    logic        ovh;
    logic        mal;
    logic [15:0] err;
    logic [15:0] err_sum;
    logic [15:0] deriv;
  } s1_t;

  // Result word
  typedef struct packed {
    logic [1:0]  status;
    logic        drive;
    logic [2:0]  fan;
    logic [2:0]  pump;
    logic        rep_v;
    logic        rep_o;
    logic        ovh;
    logic        mal;
    logic [15:0] pid;
  } res_t;

endpackage

// ===== src/cpfp_drive_map.sv =====
// ----------------------------------------------------------------------------
// Coolant controller drive mapper
// Forms the PID sum from the staged terms and maps it to fan/pump bands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cpfp_drive_map (
  input  cpfp_pkg::s1_t  s1,
  input  logic [7:0]     gain_p,
  input  logic [7:0]     gain_i,
  input  logic [7:0]     gain_d,
  input  logic [2:0]     held_fan,
  input  logic [2:0]     held_pump,
  output cpfp_pkg::res_t res
);

  logic [15:0]        prod_p;
  logic [15:0]        prod_i;
  logic [15:0]        prod_d;
  logic signed [15:0] pid;
  logic [2:0]         band_fan;
  logic [2:0]         band_pump;

  // Narrow products, wrapped to 16 bits
  assign prod_p = 16'({8'd0, gain_p} * s1.err);
  assign prod_i = 16'({8'd0, gain_i} * s1.err_sum);
  assign prod_d = 16'({8'd0, gain_d} * s1.deriv);
  assign pid    = $signed(16'(prod_p + prod_i + prod_d));

  // Map PID value to bands; dead band keeps held levels
  always_comb begin
    if (pid <= cpfp_pkg::BAND_MAX) begin
      band_fan  = cpfp_pkg::LVL_MAX;
      band_pump = cpfp_pkg::LVL_MAX;
    end else if (pid <= cpfp_pkg::BAND_HIGH) begin
      band_fan  = cpfp_pkg::LVL_MAX;
      band_pump = cpfp_pkg::LVL_HIGH;
    end else if (pid <= cpfp_pkg::BAND_AVG) begin
      band_fan  = cpfp_pkg::LVL_HIGH;
      band_pump = cpfp_pkg::LVL_AVG;
    end else if (pid <= cpfp_pkg::BAND_LOW) begin
      band_fan  = cpfp_pkg::LVL_AVG;
      band_pump = cpfp_pkg::LVL_LOW;
    end else if (pid <= cpfp_pkg::BAND_MIN) begin
      band_fan  = cpfp_pkg::LVL_LOW;
      band_pump = cpfp_pkg::LVL_LOW;
    end else if (pid > 16'sd0) begin
      band_fan  = cpfp_pkg::LVL_OFF;
      band_pump = cpfp_pkg::LVL_OFF;
    end else begin
      band_fan  = held_fan;
      band_pump = held_pump;
    end
  end

  // Assemble the result word by sample class
  always_comb begin
    res.rep_v = s1.rep_v;
    res.rep_o = s1.rep_o;
    res.ovh   = s1.ovh;
    res.mal   = s1.mal;
    res.pid   = 16'd0;
    case (s1.kind)
      cpfp_pkg::KIND_FAULT: begin
        res.status = cpfp_pkg::STATUS_SENSOR;
        res.drive  = 1'b0;
        res.fan    = cpfp_pkg::LVL_OFF;
        res.pump   = cpfp_pkg::LVL_OFF;
      end
      cpfp_pkg::KIND_HOT: begin
        res.status = cpfp_pkg::STATUS_OVERHEAT;
        res.drive  = 1'b1;
        res.fan    = cpfp_pkg::LVL_MAX;
        res.pump   = cpfp_pkg::LVL_MAX;
      end
      cpfp_pkg::KIND_COLD: begin
        res.status = cpfp_pkg::STATUS_OK;
        res.drive  = 1'b1;
        res.fan    = cpfp_pkg::LVL_OFF;
        res.pump   = cpfp_pkg::LVL_OFF;
      end
      default: begin
        res.status = cpfp_pkg::STATUS_OK;
        res.drive  = 1'b1;
        res.fan    = band_fan;
        res.pump   = band_pump;
        res.pid    = pid;
      end
    endcase
  end

endmodule

// ===== src/coolant_pid_fan_pump_controller.sv =====
// ----------------------------------------------------------------------------
// Coolant PID fan/pump controller
// Classifies each temperature sample, runs a wrapping 16-bit PID update
// and drives banded fan and pump levels with status and overheat reports.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Word
//  --------+-----------+--------------------------------------------------
//  in_     | slave     | temperature sample, 16-bit signed
//  out_    | master    | status, levels, reports, flags, PID value
//  cfg_    | slave     | register index (3 bits) and write data (16 bits)
//
//  Three register stages: input register, classify/PID-term register,
//  result register. One word per cycle is sustained while out_tready
//  is high; a sample moves through them in that order to out_tdata.
//  PID state is updated as a word enters the middle stage, held levels as
//  it enters the result register. A stalled out_tready backs up stage by
//  stage; cfg_ready is always high. Synchronous active-low reset restores
//  register defaults and clears all state.
//
`timescale 1ns / 1ps
`include "coolant_pid_fan_pump_controller_macros.svh"

module coolant_pid_fan_pump_controller (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: [15:0] temperature
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,
  // out_tdata: [1:0] status, [2] drive_valid, [5:3] fan_level,
  // [8:6] pump_level, [9] report_valid, [10] report_overheat,
  // [11] overheat_flag, [12] malfunction_flag, [28:13] pid_out, [31:29] 0
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  // Configuration registers
  logic [15:0] setpoint_r;
  logic [7:0]  gain_p_r;
  logic [7:0]  gain_i_r;
  logic [7:0]  gain_d_r;
  logic [15:0] high_limit_r;
  logic [14:0] low_margin_r;
  logic [15:0] sensor_err_r;

  // Pipeline
  logic           in_v_r;
  logic [15:0]    temp_r;
  logic           s1_v_r;
  cpfp_pkg::s1_t  s1_r;
  cpfp_pkg::s1_t  s1_nxt;
  logic           out_v_r;
  cpfp_pkg::res_t out_r;
  cpfp_pkg::res_t res;

  // Controller state
  logic [15:0] error_sum_r;
  logic [15:0] last_error_r;
  logic        ovh_r;
  logic        mal_r;
  logic [2:0]  held_fan_r;
  logic [2:0]  held_pump_r;

  logic        out_ready;
  logic        s1_ready;
  logic        in_load;
  logic        s1_load;
  logic        is_fault;
  logic        is_hot;
  logic        is_cold;
  logic [16:0] low_thr;
  logic [15:0] err;
  logic [15:0] err_sum_nxt;
  logic [15:0] deriv;

  // Stage handshakes
  assign out_ready = !out_v_r || out_tready;
  assign s1_ready  = !s1_v_r || out_ready;
  assign in_tready = !in_v_r || s1_ready;
  assign in_load   = in_v_r && s1_ready;
  assign s1_load   = s1_v_r && out_ready;
  assign cfg_ready = 1'b1;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      setpoint_r   <= 16'd40;
      gain_p_r     <= 8'd3;
      gain_i_r     <= 8'd1;
      gain_d_r     <= 8'd3;
      high_limit_r <= 16'd100;
      low_margin_r <= 15'd10;
      sensor_err_r <= 16'h8000;
    end else if (cfg_valid) begin
      case (cfg_index)
        cpfp_pkg::REG_SETPOINT:   setpoint_r   <= cfg_data;
        cpfp_pkg::REG_GAIN_P:     gain_p_r     <= cfg_data[7:0];
        cpfp_pkg::REG_GAIN_I:     gain_i_r     <= cfg_data[7:0];
        cpfp_pkg::REG_GAIN_D:     gain_d_r     <= cfg_data[7:0];
        cpfp_pkg::REG_HIGH_LIMIT: high_limit_r <= cfg_data;
        cpfp_pkg::REG_LOW_MARGIN: low_margin_r <= cfg_data[14:0];
        cpfp_pkg::REG_SENSOR_ERR: sensor_err_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      temp_r <= in_tdata;
    end
  end

  // Classify the sample and form the PID terms
  assign is_fault    = temp_r == sensor_err_r;
  assign is_hot      = $signed(temp_r) >= $signed(high_limit_r);
  assign low_thr     = {setpoint_r[15], setpoint_r} - {2'b00, low_margin_r};
  assign is_cold     = $signed({temp_r[15], temp_r}) <= $signed(low_thr);
  assign err         = setpoint_r - temp_r;
  assign err_sum_nxt = error_sum_r + err;
  assign deriv       = err - last_error_r;

  always_comb begin
    s1_nxt.err     = err;
    s1_nxt.err_sum = err_sum_nxt;
    s1_nxt.deriv   = deriv;
    s1_nxt.rep_v   = 1'b0;
    s1_nxt.rep_o   = 1'b0;
    s1_nxt.ovh     = ovh_r;
    s1_nxt.mal     = mal_r;
    if (is_fault) begin
      s1_nxt.kind = cpfp_pkg::KIND_FAULT;
      s1_nxt.mal  = 1'b1;
    end else if (is_hot) begin
      s1_nxt.kind  = cpfp_pkg::KIND_HOT;
      s1_nxt.rep_v = 1'b1;
      s1_nxt.rep_o = 1'b1;
      s1_nxt.ovh   = 1'b1;
    end else if (is_cold) begin
      s1_nxt.kind = cpfp_pkg::KIND_COLD;
    end else begin
      s1_nxt.kind  = cpfp_pkg::KIND_RUN;
      s1_nxt.rep_v = ovh_r;
      s1_nxt.ovh   = 1'b0;
    end
  end

  // Middle stage and PID state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r       <= 1'b0;
      error_sum_r  <= 16'd0;
      last_error_r <= 16'd0;
      ovh_r        <= 1'b0;
      mal_r        <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_v_r <= in_v_r;
      end
      if (in_load) begin
        ovh_r <= s1_nxt.ovh;
        mal_r <= s1_nxt.mal;
        if (s1_nxt.kind == cpfp_pkg::KIND_RUN) begin
          error_sum_r  <= err_sum_nxt;
          last_error_r <= err;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_load) begin
      s1_r <= s1_nxt;
    end
  end

  // Products, banding and result assembly
  cpfp_drive_map u_drive_map (
    .s1        (s1_r),
    .gain_p    (gain_p_r),
    .gain_i    (gain_i_r),
    .gain_d    (gain_d_r),
    .held_fan  (held_fan_r),
    .held_pump (held_pump_r),
    .res       (res)
  );

  // Result register and held levels
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r     <= 1'b0;
      held_fan_r  <= cpfp_pkg::LVL_OFF;
      held_pump_r <= cpfp_pkg::LVL_OFF;
    end else begin
      if (out_ready) begin
        out_v_r <= s1_v_r;
      end
      if (s1_load && res.drive) begin
        held_fan_r  <= res.fan;
        held_pump_r <= res.pump;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {3'b000, out_r.pid, out_r.mal, out_r.ovh, out_r.rep_o, out_r.rep_v,
                       out_r.pump, out_r.fan, out_r.drive, out_r.status};

  // Checks
  `CPFP_ASSERT_NOW(a_no_drive_off, clk, rst_n, out_v_r && !out_r.drive, (out_r.fan == cpfp_pkg::LVL_OFF) && (out_r.pump == cpfp_pkg::LVL_OFF))
  `CPFP_ASSERT_NOW(a_overheat_max, clk, rst_n, out_v_r && (out_r.status == cpfp_pkg::STATUS_OVERHEAT), (out_r.fan == cpfp_pkg::LVL_MAX) && (out_r.pump == cpfp_pkg::LVL_MAX) && out_r.rep_v && out_r.ovh)
  `CPFP_ASSERT_NOW(a_clear_report, clk, rst_n, out_v_r && out_r.rep_v && !out_r.rep_o, (out_r.status == cpfp_pkg::STATUS_OK) && !out_r.ovh)
  `CPFP_ASSERT_NEXT(a_mal_sticky, clk, rst_n, mal_r, mal_r)

endmodule

// ===== tb/tb_coolant_pid_fan_pump_controller.sv =====
// ----------------------------------------------------------------------------
// Coolant PID fan/pump controller testbench
// Streams temperature samples into the controller and checks every result
// word against an in-bench model of the classifier, the wrapping PID update
// and the level bands, under random idling, long stalls and register changes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_coolant_pid_fan_pump_controller;

  // Index past the end of the register list, must be ignored
  localparam logic [2:0] REG_UNUSED = 3'd7;
  localparam int DRAIN_CYCLES = 8;

  typedef struct {
    logic [1:0]  status;
    logic        drive;
    logic [2:0]  fan;
    logic [2:0]  pump;
    logic        rep_v;
    logic        rep_o;
    logic        ovh;
    logic        mal;
    logic [15:0] pid;
  } tick_result_t;

  typedef struct {
    logic [15:0] setpoint;
    logic [7:0]  gain_p;
    logic [7:0]  gain_i;
    logic [7:0]  gain_d;
    logic [15:0] high_limit;
    logic [14:0] low_margin;
    logic [15:0] sensor_err;
  } ctrl_settings_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  // Model copy of registers and state
  logic [15:0] m_setpoint, m_high_limit, m_sensor_err;
  logic [7:0]  m_gain_p, m_gain_i, m_gain_d;
  logic [14:0] m_low_margin;
  logic [15:0] m_error_sum, m_last_error;
  logic        m_overheat, m_malfunction;
  logic [2:0]  m_held_fan, m_held_pump;

  tick_result_t   expected_results[$];
  ctrl_settings_t active;

  int mismatches = 0;
  int samples_accepted = 0;
  int results_checked = 0;
  int reg_writes = 0;
  int n_fault = 0, n_hot = 0, n_cold = 0, n_pid = 0, n_deadband = 0;

  // Idling controls for the two sides
  bit src_steady = 1'b0;
  bit sink_steady = 1'b0;
  int sink_hold_request = 0;

  coolant_pid_fan_pump_controller dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  initial begin
    #2_000_000;
    $display("tb_coolant_pid_fan_pump_controller failed");
    $finish;
  end

  // Receiver: random idling, steady stretches, and counted hold-offs
  always @(negedge clk) begin
    int hold_left;
    if (sink_hold_request > 0) begin
      hold_left = sink_hold_request;
      sink_hold_request = 0;
    end
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left = hold_left - 1;
    end else if (sink_steady) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(99) >= 19);
    end
  end

  function automatic int clamp16(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic void reset_model();
    m_setpoint = 16'd40;
    m_gain_p = 8'd3;
    m_gain_i = 8'd1;
    m_gain_d = 8'd3;
    m_high_limit = 16'd100;
    m_low_margin = 15'd10;
    m_sensor_err = 16'h8000;
    m_error_sum = '0;
    m_last_error = '0;
    m_overheat = 1'b0;
    m_malfunction = 1'b0;
    m_held_fan = cpfp_pkg::LVL_OFF;
    m_held_pump = cpfp_pkg::LVL_OFF;
  endfunction

  function automatic void apply_reg(logic [2:0] idx, logic [15:0] data);
    reg_writes++;
    case (idx)
      cpfp_pkg::REG_SETPOINT:   m_setpoint = data;
      cpfp_pkg::REG_GAIN_P:     m_gain_p = data[7:0];
      cpfp_pkg::REG_GAIN_I:     m_gain_i = data[7:0];
      cpfp_pkg::REG_GAIN_D:     m_gain_d = data[7:0];
      cpfp_pkg::REG_HIGH_LIMIT: m_high_limit = data;
      cpfp_pkg::REG_LOW_MARGIN: m_low_margin = data[14:0];
      cpfp_pkg::REG_SENSOR_ERR: m_sensor_err = data;
      default: ;
    endcase
  endfunction

  // Classify one sample, advance the PID state and band the output
  function automatic tick_result_t control_tick(logic [15:0] t);
    tick_result_t r;
    int temp, cold_edge;
    logic [15:0] err, deriv;
    logic signed [15:0] pid;
    r = '{default: '0};
    temp = $signed(t);
    cold_edge = int'($signed(m_setpoint)) - int'(m_low_margin);
    if (t == m_sensor_err) begin
      m_malfunction = 1'b1;
      r.status = cpfp_pkg::STATUS_SENSOR;
      n_fault++;
    end else if (temp >= int'($signed(m_high_limit))) begin
      m_overheat = 1'b1;
      r.status = cpfp_pkg::STATUS_OVERHEAT;
      r.drive = 1'b1;
      r.fan = cpfp_pkg::LVL_MAX;
      r.pump = cpfp_pkg::LVL_MAX;
      r.rep_v = 1'b1;
      r.rep_o = 1'b1;
      n_hot++;
    end else if (temp <= cold_edge) begin
      r.drive = 1'b1;
      r.fan = cpfp_pkg::LVL_OFF;
      r.pump = cpfp_pkg::LVL_OFF;
      n_cold++;
    end else begin
      if (m_overheat) begin
        m_overheat = 1'b0;
        r.rep_v = 1'b1;
      end
      err = m_setpoint - t;
      m_error_sum = m_error_sum + err;
      deriv = err - m_last_error;
      m_last_error = err;
      pid = m_gain_p * err + m_gain_i * m_error_sum + m_gain_d * deriv;
      r.pid = pid;
      r.drive = 1'b1;
      n_pid++;
      if (pid <= cpfp_pkg::BAND_MAX) begin
        r.fan = cpfp_pkg::LVL_MAX;  r.pump = cpfp_pkg::LVL_MAX;
      end else if (pid <= cpfp_pkg::BAND_HIGH) begin
        r.fan = cpfp_pkg::LVL_MAX;  r.pump = cpfp_pkg::LVL_HIGH;
      end else if (pid <= cpfp_pkg::BAND_AVG) begin
        r.fan = cpfp_pkg::LVL_HIGH; r.pump = cpfp_pkg::LVL_AVG;
      end else if (pid <= cpfp_pkg::BAND_LOW) begin
        r.fan = cpfp_pkg::LVL_AVG;  r.pump = cpfp_pkg::LVL_LOW;
      end else if (pid <= cpfp_pkg::BAND_MIN) begin
        r.fan = cpfp_pkg::LVL_LOW;  r.pump = cpfp_pkg::LVL_LOW;
      end else if (pid > 0) begin
        r.fan = cpfp_pkg::LVL_OFF;  r.pump = cpfp_pkg::LVL_OFF;
      end else begin
        // dead band: drive the held levels again
        r.fan = m_held_fan;
        r.pump = m_held_pump;
        n_deadband++;
      end
    end
    if (r.drive) begin
      m_held_fan = r.fan;
      m_held_pump = r.pump;
    end
    r.ovh = m_overheat;
    r.mal = m_malfunction;
    return r;
  endfunction

  task automatic compare_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
    end
  endtask

  task automatic check_result(input logic [31:0] word);
    tick_result_t w;
    if (expected_results.size() == 0) begin
      mismatches++;
      $display("%0t: result with nothing expected, expected none, got 0x%0h", $time, word);
    end else begin
      w = expected_results.pop_front();
      results_checked++;
      compare_field("status", w.status, word[1:0]);
      compare_field("drive_valid", w.drive, word[2]);
      compare_field("fan_level", w.fan, word[5:3]);
      compare_field("pump_level", w.pump, word[8:6]);
      compare_field("report_valid", w.rep_v, word[9]);
      compare_field("report_overheat", w.rep_o, word[10]);
      compare_field("overheat_flag", w.ovh, word[11]);
      compare_field("malfunction_flag", w.mal, word[12]);
      compare_field("pid_out", w.pid, word[28:13]);
      compare_field("padding", 16'd0, word[31:29]);
    end
  endtask

  // Watch all three channels at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) check_result(out_tdata);
      if (in_tvalid && in_tready) begin
        expected_results.push_back(control_tick(in_tdata));
        samples_accepted++;
      end
      if (cfg_valid && cfg_ready) apply_reg(cfg_index, cfg_data);
    end
  end

  // Offer one sample; valid stays high after acceptance
  task automatic send_sample(input logic [15:0] t);
    @(negedge clk);
    while (!src_steady && $urandom_range(99) < 19) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= t;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic stop_samples();
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  // Hold until every expected result has come, then let the pipe settle
  task automatic wait_drain();
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Write every register; unused upper bits carry junk that must be dropped
  task automatic apply_settings(input ctrl_settings_t s);
    stop_samples();
    wait_drain();
    write_reg(cpfp_pkg::REG_SETPOINT, s.setpoint);
    write_reg(cpfp_pkg::REG_GAIN_P, {8'($urandom), s.gain_p});
    write_reg(cpfp_pkg::REG_GAIN_I, {8'($urandom), s.gain_i});
    write_reg(cpfp_pkg::REG_GAIN_D, {8'($urandom), s.gain_d});
    write_reg(cpfp_pkg::REG_HIGH_LIMIT, s.high_limit);
    write_reg(cpfp_pkg::REG_LOW_MARGIN, {1'($urandom_range(1)), s.low_margin});
    write_reg(cpfp_pkg::REG_SENSOR_ERR, s.sensor_err);
    @(negedge clk);
    cfg_valid <= 1'b0;
    active = s;
  endtask

  // Mostly samples inside the PID window near setpoint, plus edges and noise
  function automatic logic [15:0] draw_temperature();
    int roll, sp, hi, lo, v;
    roll = $urandom_range(99);
    sp = $signed(active.setpoint);
    hi = clamp16(int'($signed(active.high_limit)) - 1);
    lo = clamp16(sp - int'(active.low_margin) + 1);
    if (roll < 6) return active.sensor_err;
    if (roll < 14) return 16'(clamp16(int'($signed(active.high_limit))
                                      + int'($urandom_range(40))));
    if (roll < 22) return 16'(clamp16(sp - int'(active.low_margin)
                                      - int'($urandom_range(40))));
    if (roll < 32 || lo > hi) return 16'($urandom);
    v = sp + int'($urandom_range(120)) - 60;
    if (v < lo) v = lo;
    if (v > hi) v = hi;
    return 16'(v);
  endfunction

  function automatic ctrl_settings_t random_settings();
    ctrl_settings_t s;
    int sp;
    sp = int'($urandom_range(4000)) - 2000;
    s.setpoint = 16'(sp);
    s.gain_p = 8'($urandom_range(6));
    s.gain_i = 8'($urandom_range(3));
    s.gain_d = 8'($urandom_range(6));
    s.low_margin = 15'($urandom_range(80));
    s.high_limit = 16'(sp + int'($urandom_range(200, 20)));
    s.sensor_err = ($urandom_range(3) == 0) ? 16'($urandom) : 16'h8000;
    return s;
  endfunction

  // Reset thresholds: cold edge, overheat entry and clearing, range ends
  task automatic test_default_thresholds();
    logic [15:0] temps[8] = '{16'd40, 16'd30, 16'd31, 16'd100, 16'd99,
                              16'h7FFF, 16'd55, 16'h8001};
    foreach (temps[i]) send_sample(temps[i]);
    stop_samples();
  endtask

  // Pure proportional gain so the PID value steps across every band edge
  task automatic test_band_edges();
    ctrl_settings_t s;
    logic [15:0] temps[10] = '{-16'sd50, 16'd0, 16'd10, 16'd20, 16'd30,
                               16'd40, 16'd50, 16'd5, 16'd9, -16'sd1};
    s = '{setpoint: 16'd0, gain_p: 8'd1, gain_i: 8'd0, gain_d: 8'd0,
          high_limit: 16'd1000, low_margin: 15'd100, sensor_err: 16'h8000};
    apply_settings(s);
    foreach (temps[i]) send_sample(temps[i]);
    stop_samples();
  endtask

  // Sensor error code sets the sticky flag, also ahead of the overheat check
  task automatic test_sensor_fault();
    ctrl_settings_t s;
    send_sample(16'h8000);
    send_sample(16'd0);
    s = active;
    s.sensor_err = 16'h7FFF;
    apply_settings(s);
    send_sample(16'h7FFF);
    send_sample(16'd2000);
    stop_samples();
  endtask

  task automatic test_random_phases();
    ctrl_settings_t s;
    for (int phase = 0; phase < 14; phase++) begin
      case (phase)
        0: s = '{setpoint: 16'h7FFF, gain_p: 8'd0, gain_i: 8'd0, gain_d: 8'd0,
                 high_limit: 16'h8000, low_margin: 15'd0, sensor_err: 16'h0000};
        1: s = '{setpoint: 16'h8000, gain_p: 8'hFF, gain_i: 8'hFF, gain_d: 8'hFF,
                 high_limit: 16'h7FFF, low_margin: 15'h7FFF, sensor_err: 16'h7FFF};
        2: s = '{setpoint: 16'h0000, gain_p: 8'hFF, gain_i: 8'hFF, gain_d: 8'hFF,
                 high_limit: 16'h7FFF, low_margin: 15'h7FFF, sensor_err: 16'hFFFF};
        default: s = random_settings();
      endcase
      apply_settings(s);
      if (phase == 5) begin
        write_reg(REG_UNUSED, 16'hFFFF);
        @(negedge clk);
        cfg_valid <= 1'b0;
      end
      repeat (95) send_sample(draw_temperature());
    end
    stop_samples();
  endtask

  // Receiver holds off while samples keep coming, so the input stalls
  task automatic test_long_stall();
    apply_settings(random_settings());
    sink_hold_request = 400;
    repeat (60) send_sample(draw_temperature());
    stop_samples();
    wait_drain();
  endtask

  // Back-to-back stream with no idling on either side
  task automatic test_steady_stream();
    apply_settings(random_settings());
    src_steady = 1'b1;
    sink_steady = 1'b1;
    repeat (200) send_sample(draw_temperature());
    stop_samples();
    wait_drain();
    src_steady = 1'b0;
    sink_steady = 1'b0;
  endtask

  initial begin
    reset_model();
    active = '{setpoint: 16'd40, gain_p: 8'd3, gain_i: 8'd1, gain_d: 8'd3,
               high_limit: 16'd100, low_margin: 15'd10, sensor_err: 16'h8000};
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    test_default_thresholds();
    test_band_edges();
    test_sensor_fault();
    test_random_phases();
    test_long_stall();
    test_steady_stream();
    wait_drain();
    $display("Ran %0d samples, checked %0d results, %0d register writes, %0d mismatches",
             samples_accepted, results_checked, reg_writes, mismatches);
    $display("Sample mix: %0d sensor faults, %0d overheat, %0d cold, %0d PID (%0d dead band)",
             n_fault, n_hot, n_cold, n_pid, n_deadband);
    if (mismatches == 0) begin
      $display("tb_coolant_pid_fan_pump_controller passed");
    end else begin
      $display("tb_coolant_pid_fan_pump_controller failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/cpfp_pkg.sv
src/cpfp_drive_map.sv
src/coolant_pid_fan_pump_controller.sv
tb/tb_coolant_pid_fan_pump_controller.sv
